// File: rtl/hcbp_pkg.sv
// hcbp_pkg: widths, table sizing, opcodes and the packer result bundle
// shared by the huffman code bit packer modules; depends on nothing
`default_nettype none

package hcbp_pkg;

    localparam int NUM_SYMBOLS  = 256;
    localparam int MAX_CODE_LEN = 32;

    localparam int OP_W     = 2;
    localparam int SYM_W    = 8;
    localparam int LEN_W    = 6;
    localparam int CODE_W   = 32;
    localparam int BYTE_W   = 8;
    localparam int PAD_W    = 3;
    localparam int PEND_W   = BYTE_W - 1;
    localparam int PCNT_W   = 3;
    localparam int MAX_RES  = 4;
    localparam int RCNT_W   = 3;
    localparam int RIDX_W   = 2;
    localparam int WORD_W   = PEND_W + CODE_W + 1;

    localparam int TBL_AW   = (NUM_SYMBOLS > 1) ? $clog2(NUM_SYMBOLS) : 1;
    localparam int LEN_CAP  = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_ENCODE = 2'd1,
        OP_FLUSH  = 2'd2
    } op_t;

    typedef struct packed {
        logic [RCNT_W-1:0]               count;
        logic [MAX_RES-1:0][BYTE_W-1:0]  bytes;
        logic                            present;
        logic [PAD_W-1:0]                pad;
        logic [PEND_W-1:0]               pend_next;
        logic [PCNT_W-1:0]               pcnt_next;
    } pack_t;

endpackage

`default_nettype wire

// File: rtl/hcbp_table.sv
// hcbp_table: symbol code table, length and code memories with registered read
// length entries carry reset-cleared valid bits; depends on hcbp_pkg
`default_nettype none

module hcbp_table (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        wr_en,
    input  wire logic [hcbp_pkg::TBL_AW-1:0] wr_addr,
    input  wire logic [hcbp_pkg::LEN_W-1:0]  wr_len,
    input  wire logic [hcbp_pkg::CODE_W-1:0] wr_code,
    input  wire logic                        rd_en,
    input  wire logic [hcbp_pkg::TBL_AW-1:0] rd_addr,
    output logic      [hcbp_pkg::LEN_W-1:0]  rd_len,
    output logic      [hcbp_pkg::CODE_W-1:0] rd_code
);
    import hcbp_pkg::*;

    logic [LEN_W-1:0]       len_mem  [NUM_SYMBOLS];
    logic [CODE_W-1:0]      code_mem [NUM_SYMBOLS];
    logic [NUM_SYMBOLS-1:0] valid_reg;
    logic [LEN_W-1:0]       rd_len_reg;
    logic [CODE_W-1:0]      rd_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            len_mem[wr_addr]  <= wr_len;
            code_mem[wr_addr] <= wr_code;
        end
        if (rd_en)
        begin
            rd_len_reg  <= valid_reg[rd_addr] ? len_mem[rd_addr] : '0;
            rd_code_reg <= code_mem[rd_addr];
        end
    end

    assign rd_len  = rd_len_reg;
    assign rd_code = rd_code_reg;

endmodule

`default_nettype wire

// File: rtl/hcbp_pack.sv
// hcbp_pack: combines one looked-up code with the pending bits into up to
// four output bytes and the next pending state, or flushes the pending bits into one padded byte; depends on hcbp_pkg
`default_nettype none

module hcbp_pack (
    input  wire logic [hcbp_pkg::OP_W-1:0]   op,
    input  wire logic                        sym_ok,
    input  wire logic [hcbp_pkg::LEN_W-1:0]  len,
    input  wire logic [hcbp_pkg::CODE_W-1:0] code,
    input  wire logic [hcbp_pkg::PEND_W-1:0] pend,
    input  wire logic [hcbp_pkg::PCNT_W-1:0] pcnt,
    output hcbp_pkg::pack_t                  res
);
    import hcbp_pkg::*;

    logic [LEN_W-1:0]  total;
    logic [LEN_W-1:0]  shamt;
    logic [CODE_W-1:0] code_al;
    logic [WORD_W-1:0] word;
    logic [RCNT_W-1:0] nbytes;

    // pending bits are kept left-aligned
    always_comb
    begin
        total   = LEN_W'(pcnt) + len;
        shamt   = LEN_W'(CODE_W) - len;
        code_al = code << shamt;
        word    = {pend, {(CODE_W + 1){1'b0}}}
                | ({code_al, {(WORD_W - CODE_W){1'b0}}} >> pcnt);
        nbytes  = total[LEN_W-1:3];

        res           = '0;
        res.pend_next = pend;
        res.pcnt_next = pcnt;

        unique case (op)
            OP_ENCODE:
            begin
                if (sym_ok && (len != '0))
                begin
                    res.count     = nbytes;
                    res.present   = 1'b1;
                    res.pcnt_next = total[2:0];
                    res.bytes[0]  = word[WORD_W-1 -: BYTE_W];
                    res.bytes[1]  = word[WORD_W-1-BYTE_W -: BYTE_W];
                    res.bytes[2]  = word[WORD_W-1-2*BYTE_W -: BYTE_W];
                    res.bytes[3]  = word[WORD_W-1-3*BYTE_W -: BYTE_W];
                    case (nbytes)
                        3'd0:    res.pend_next = word[WORD_W-1 -: PEND_W];
                        3'd1:    res.pend_next = word[WORD_W-1-BYTE_W -: PEND_W];
                        3'd2:    res.pend_next = word[WORD_W-1-2*BYTE_W -: PEND_W];
                        3'd3:    res.pend_next = word[WORD_W-1-3*BYTE_W -: PEND_W];
                        default: res.pend_next = word[WORD_W-1-4*BYTE_W -: PEND_W];
                    endcase
                end
            end
            OP_FLUSH:
            begin
                res.count     = RCNT_W'(1);
                res.present   = (pcnt != '0);
                res.pad       = PAD_W'(3'd0 - pcnt);
                res.bytes[0]  = {pend, 1'b0};
                res.pend_next = '0;
                res.pcnt_next = '0;
            end
            default:
            begin
                res.count = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/huffman_code_bit_packer.sv
// huffman_code_bit_packer: static-table huffman encoder, table load, encode
// and flush; depends on hcbp_pkg, hcbp_table and hcbp_pack
//
//   channel | handshake            | payload
//   input   | in_valid / in_stall  | opcode, symbol, code_length, code_bits
//   output  | out_valid / out_stall| out_byte, byte_present, pad_bits, last
//
// one item accepted per cycle while in_stall is low; a result passes the table read register, then the result register
// results leave one byte per cycle while out_stall is low, from a four-entry result
// register, so an encode giving n bytes holds that register until its last byte leaves and stalls input after it
// table valid bits clear at reset, asynchronously and all together, no clearing pass
// out_stall holds the result register and, once the lookup stage holds an item that gives bytes, input
`default_nettype none

module huffman_code_bit_packer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [hcbp_pkg::OP_W-1:0]   opcode,
    input  wire logic [hcbp_pkg::SYM_W-1:0]  symbol,
    input  wire logic [hcbp_pkg::LEN_W-1:0]  code_length,
    input  wire logic [hcbp_pkg::CODE_W-1:0] code_bits,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic      [hcbp_pkg::BYTE_W-1:0] out_byte,
    output logic                             byte_present,
    output logic      [hcbp_pkg::PAD_W-1:0]  pad_bits,
    output logic                             last
);
    import hcbp_pkg::*;

    logic                            in_xfer;
    logic                            out_xfer;
    logic                            sym_ok;
    logic                            wr_en;
    logic [LEN_W-1:0]                wr_len;
    logic [LEN_W-1:0]                tbl_len;
    logic [CODE_W-1:0]               tbl_code;
    pack_t                           pk;
    logic                            grp_free;
    logic                            s1_adv;

    logic                            s1_valid_reg;
    logic [OP_W-1:0]                 s1_op_reg;
    logic                            s1_sym_ok_reg;
    logic [PEND_W-1:0]               pend_reg;
    logic [PCNT_W-1:0]               pcnt_reg;
    logic                            grp_valid_reg;
    logic [MAX_RES-1:0][BYTE_W-1:0]  grp_bytes_reg;
    logic [RCNT_W-1:0]               grp_cnt_reg;
    logic [RIDX_W-1:0]               grp_idx_reg;
    logic                            grp_present_reg;
    logic [PAD_W-1:0]                grp_pad_reg;

    assign in_xfer  = in_valid && !in_stall;
    assign out_xfer = out_valid && !out_stall;
    assign sym_ok   = ({1'b0, symbol} < (SYM_W + 1)'(NUM_SYMBOLS));
    assign wr_en    = in_xfer && (opcode == OP_LOAD) && sym_ok;
    assign wr_len   = (code_length > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : code_length;

    hcbp_table u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (symbol[TBL_AW-1:0]),
        .wr_len  (wr_len),
        .wr_code (code_bits),
        .rd_en   (in_xfer),
        .rd_addr (symbol[TBL_AW-1:0]),
        .rd_len  (tbl_len),
        .rd_code (tbl_code)
    );

    hcbp_pack u_pack (
        .op     (s1_op_reg),
        .sym_ok (s1_sym_ok_reg),
        .len    (tbl_len),
        .code   (tbl_code),
        .pend   (pend_reg),
        .pcnt   (pcnt_reg),
        .res    (pk)
    );

    assign last     = (RCNT_W'(grp_idx_reg) + RCNT_W'(1)) == grp_cnt_reg;
    assign grp_free = !grp_valid_reg || (out_xfer && last);
    assign s1_adv   = s1_valid_reg && ((pk.count == '0) || grp_free);
    assign in_stall = s1_valid_reg && !s1_adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            pend_reg      <= '0;
            pcnt_reg      <= '0;
            grp_valid_reg <= 1'b0;
            grp_cnt_reg   <= '0;
            grp_idx_reg   <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_adv)
            begin
                pend_reg <= pk.pend_next;
                pcnt_reg <= pk.pcnt_next;
            end

            if (s1_adv && (pk.count != '0))
            begin
                grp_valid_reg <= 1'b1;
                grp_cnt_reg   <= pk.count;
                grp_idx_reg   <= '0;
            end
            else if (out_xfer)
            begin
                if (last)
                begin
                    grp_valid_reg <= 1'b0;
                end
                else
                begin
                    grp_idx_reg <= grp_idx_reg + RIDX_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg     <= opcode;
            s1_sym_ok_reg <= sym_ok;
        end
        if (s1_adv && (pk.count != '0))
        begin
            grp_bytes_reg   <= pk.bytes;
            grp_present_reg <= pk.present;
            grp_pad_reg     <= pk.pad;
        end
    end

    assign out_valid    = grp_valid_reg;
    assign out_byte     = grp_bytes_reg[grp_idx_reg];
    assign byte_present = grp_present_reg;
    assign pad_bits     = grp_pad_reg;

`ifndef SYNTHESIS
    a_more_after_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=> out_valid)
        else $error("result group dropped before its last byte");

    a_idx_in_group: assert property (@(posedge clk) disable iff (!rst_n)
        grp_valid_reg |-> (RCNT_W'(grp_idx_reg) < grp_cnt_reg))
        else $error("result index beyond group count");

    a_stall_needs_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && grp_valid_reg)
        else $error("input stalled with nothing in flight");

    a_empty_flush: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_present |-> last && (pad_bits == '0))
        else $error("empty flush result malformed");

    a_pad_only_flush: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (pad_bits != '0) |-> last && byte_present)
        else $error("pad bits on a non-flush result");
`endif

endmodule

`default_nettype wire
